### src/density_matrix_partial_trace_assert.svh
// assertion macros used by the checker file
`ifndef DENSITY_MATRIX_PARTIAL_TRACE_ASSERT_SVH
`define DENSITY_MATRIX_PARTIAL_TRACE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define DMPT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dmpt check failed");

// next-cycle implication, disabled during reset
`define DMPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dmpt check failed");

`endif

### src/dmpt_pkg.sv
package dmpt_pkg;

    localparam int MAX_QUBITS    = 6;
    localparam int VALUE_BITS    = 32;
    localparam int ACC_BITS      = 38;
    localparam int ADDR_BITS     = 2 * MAX_QUBITS;
    localparam int QC_BITS       = 3;
    localparam int CFG_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_BITS     = 2;
    localparam int QCNT_BITS     = QPTR_BITS + 1;

    localparam logic [QC_BITS-1:0]    QC_RESET   = 3'd6;
    localparam logic [MAX_QUBITS-1:0] MASK_RESET = '0;

    typedef enum logic [1:0] {
        OP_ACCUM = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic {
        REG_QUBIT_COUNT = 1'b0,
        REG_TRACED_MASK = 1'b1
    } reg_sel_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CLEAR
    } back_state_t;

    typedef struct packed {
        op_t                          op;
        logic [ADDR_BITS-1:0]         addr;
        logic signed [VALUE_BITS-1:0] value_re;
        logic signed [VALUE_BITS-1:0] value_im;
    } cmd_t;

    typedef struct packed {
        logic signed [ACC_BITS-1:0] re;
        logic signed [ACC_BITS-1:0] im;
    } acc_entry_t;

    typedef struct packed {
        logic init_clear;
    } back_status_t;

    // bit q set when qubit q is below the effective qubit count
    function automatic logic [MAX_QUBITS-1:0] qubit_mask(input logic [QC_BITS-1:0] qc);
        logic [MAX_QUBITS-1:0] m;
        m = '0;
        for (int q = 0; q < MAX_QUBITS; q++) begin
            m[q] = (q < int'(qc));
        end
        return m;
    endfunction

    // compact the untraced bits of an index, lowest qubit first
    function automatic logic [MAX_QUBITS-1:0] pack_untraced(
        input logic [MAX_QUBITS-1:0] full,
        input logic [MAX_QUBITS-1:0] traced
    );
        logic [MAX_QUBITS-1:0] packed_idx;
        int k;
        packed_idx = '0;
        k = 0;
        for (int q = 0; q < MAX_QUBITS; q++) begin
            if (!traced[q]) begin
                packed_idx[k] = full[q];
                k++;
            end
        end
        return packed_idx;
    endfunction

    // low bits kept for a reduced index: one per untraced active qubit
    function automatic logic [MAX_QUBITS-1:0] reduced_mask(
        input logic [MAX_QUBITS-1:0] untraced
    );
        logic [MAX_QUBITS-1:0] m;
        int cnt;
        cnt = 0;
        for (int q = 0; q < MAX_QUBITS; q++) begin
            cnt += int'(untraced[q]);
        end
        for (int i = 0; i < MAX_QUBITS; i++) begin
            m[i] = (i < cnt);
        end
        return m;
    endfunction

endpackage

### src/dmpt_front.sv
module dmpt_front (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [1:0]                             opcode,
    input  logic [dmpt_pkg::MAX_QUBITS-1:0]        row_index,
    input  logic [dmpt_pkg::MAX_QUBITS-1:0]        col_index,
    input  logic signed [dmpt_pkg::VALUE_BITS-1:0] value_re,
    input  logic signed [dmpt_pkg::VALUE_BITS-1:0] value_im,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [dmpt_pkg::CFG_ADDR_BITS-1:0]     paddr,
    input  logic [dmpt_pkg::APB_DATA_BITS-1:0]     pwdata,
    output logic [dmpt_pkg::APB_DATA_BITS-1:0]     prdata,
    output logic                                   pready,
    input  logic                                   queue_full,
    input  dmpt_pkg::back_status_t                 back_status,
    output logic                                   push,
    output dmpt_pkg::cmd_t                         push_cmd
);

    logic [dmpt_pkg::QC_BITS-1:0]    qubit_count_reg;
    logic [dmpt_pkg::MAX_QUBITS-1:0] traced_mask_reg;

    logic                            cfg_write;
    dmpt_pkg::reg_sel_t              reg_sel;
    logic [dmpt_pkg::MAX_QUBITS-1:0] qmask;
    logic [dmpt_pkg::MAX_QUBITS-1:0] traced;
    logic [dmpt_pkg::MAX_QUBITS-1:0] row_act;
    logic [dmpt_pkg::MAX_QUBITS-1:0] col_act;
    logic [dmpt_pkg::MAX_QUBITS-1:0] rmask;
    logic                            diag_match;
    logic                            accept;
    dmpt_pkg::op_t                   op;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_sel   = dmpt_pkg::reg_sel_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qubit_count_reg <= dmpt_pkg::QC_RESET;
            traced_mask_reg <= dmpt_pkg::MASK_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                dmpt_pkg::REG_QUBIT_COUNT: qubit_count_reg <= pwdata[dmpt_pkg::QC_BITS-1:0];
                dmpt_pkg::REG_TRACED_MASK: traced_mask_reg <= pwdata[dmpt_pkg::MAX_QUBITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            dmpt_pkg::REG_QUBIT_COUNT:
                prdata = dmpt_pkg::APB_DATA_BITS'(qubit_count_reg);
            dmpt_pkg::REG_TRACED_MASK:
                prdata = dmpt_pkg::APB_DATA_BITS'(traced_mask_reg);
            default:
                prdata = '0;
        endcase
    end

    // no new transaction while the queue is full or the store is being swept after reset
    assign busy   = queue_full || back_status.init_clear;
    assign accept = start && !busy;
    assign op     = dmpt_pkg::op_t'(opcode);

    assign qmask      = dmpt_pkg::qubit_mask(qubit_count_reg);
    assign traced     = traced_mask_reg & qmask;
    assign row_act    = row_index & qmask;
    assign col_act    = col_index & qmask;
    assign diag_match = ((row_act ^ col_act) & traced) == '0;
    assign rmask      = dmpt_pkg::reduced_mask(~traced & qmask);

    always_comb
    begin
        push_cmd.op       = op;
        push_cmd.value_re = value_re;
        push_cmd.value_im = value_im;
        push_cmd.addr     = {dmpt_pkg::pack_untraced(row_act, traced),
                             dmpt_pkg::pack_untraced(col_act, traced)};
        push              = 1'b0;
        case (op)
            dmpt_pkg::OP_ACCUM:
            begin
                // off-diagonal in a traced qubit: element drops out of the trace
                push = accept && diag_match;
            end
            dmpt_pkg::OP_READ:
            begin
                push          = accept;
                push_cmd.addr = {row_index & rmask, col_index & rmask};
            end
            dmpt_pkg::OP_CLEAR:
            begin
                push = accept;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

endmodule

### src/dmpt_cmd_queue.sv
module dmpt_cmd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  dmpt_pkg::cmd_t push_cmd,
    input  logic           pop,
    output dmpt_pkg::cmd_t head_cmd,
    output logic           empty,
    output logic           full
);

    dmpt_pkg::cmd_t                 entry_reg [dmpt_pkg::QUEUE_DEPTH];
    logic [dmpt_pkg::QPTR_BITS-1:0] wr_ptr_reg;
    logic [dmpt_pkg::QPTR_BITS-1:0] wr_ptr_next;
    logic [dmpt_pkg::QPTR_BITS-1:0] rd_ptr_reg;
    logic [dmpt_pkg::QPTR_BITS-1:0] rd_ptr_next;
    logic [dmpt_pkg::QCNT_BITS-1:0] count_reg;
    logic [dmpt_pkg::QCNT_BITS-1:0] count_next;
    logic                           do_push;
    logic                           do_pop;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == dmpt_pkg::QCNT_BITS'(dmpt_pkg::QUEUE_DEPTH));
    assign head_cmd = entry_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### src/dmpt_back.sv
module dmpt_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  dmpt_pkg::cmd_t                       head_cmd,
    input  logic                                 empty,
    output logic                                 pop,
    output dmpt_pkg::back_status_t               back_status,
    output logic                                 done,
    output logic signed [dmpt_pkg::ACC_BITS-1:0] sum_re,
    output logic signed [dmpt_pkg::ACC_BITS-1:0] sum_im
);

    localparam int EXT_BITS = dmpt_pkg::ACC_BITS - dmpt_pkg::VALUE_BITS;

    dmpt_pkg::acc_entry_t mem [1 << dmpt_pkg::ADDR_BITS];

    dmpt_pkg::back_state_t            state_reg;
    dmpt_pkg::back_state_t            state_next;
    dmpt_pkg::cmd_t                   cur_reg;
    dmpt_pkg::cmd_t                   cur_next;
    logic [dmpt_pkg::ADDR_BITS-1:0]   clr_cnt_reg;
    logic [dmpt_pkg::ADDR_BITS-1:0]   clr_cnt_next;
    logic                             init_reg;
    logic                             init_next;
    logic                             done_reg;
    logic                             done_next;
    logic signed [dmpt_pkg::ACC_BITS-1:0] sum_re_reg;
    logic signed [dmpt_pkg::ACC_BITS-1:0] sum_re_next;
    logic signed [dmpt_pkg::ACC_BITS-1:0] sum_im_reg;
    logic signed [dmpt_pkg::ACC_BITS-1:0] sum_im_next;

    dmpt_pkg::acc_entry_t             rd_data_reg;
    logic [dmpt_pkg::ADDR_BITS-1:0]   rd_addr;
    logic                             wr_en;
    logic [dmpt_pkg::ADDR_BITS-1:0]   wr_addr;
    dmpt_pkg::acc_entry_t             wr_data;
    logic signed [dmpt_pkg::ACC_BITS-1:0] add_re;
    logic signed [dmpt_pkg::ACC_BITS-1:0] add_im;

    assign add_re = {{EXT_BITS{cur_reg.value_re[dmpt_pkg::VALUE_BITS-1]}}, cur_reg.value_re};
    assign add_im = {{EXT_BITS{cur_reg.value_im[dmpt_pkg::VALUE_BITS-1]}}, cur_reg.value_im};

    always_comb
    begin
        state_next   = state_reg;
        cur_next     = cur_reg;
        clr_cnt_next = clr_cnt_reg;
        init_next    = init_reg;
        done_next    = 1'b0;
        sum_re_next  = sum_re_reg;
        sum_im_next  = sum_im_reg;
        pop          = 1'b0;
        rd_addr      = head_cmd.addr;
        wr_en        = 1'b0;
        wr_addr      = cur_reg.addr;
        wr_data      = rd_data_reg;
        case (state_reg)
            dmpt_pkg::ST_IDLE:
            begin
                if (!empty)
                begin
                    pop = 1'b1;
                    if (head_cmd.op == dmpt_pkg::OP_CLEAR)
                    begin
                        clr_cnt_next = '0;
                        state_next   = dmpt_pkg::ST_CLEAR;
                    end
                    else
                    begin
                        // memory read of the head address is issued this cycle
                        cur_next   = head_cmd;
                        state_next = dmpt_pkg::ST_EXEC;
                    end
                end
            end
            dmpt_pkg::ST_EXEC:
            begin
                state_next = dmpt_pkg::ST_IDLE;
                if (cur_reg.op == dmpt_pkg::OP_READ)
                begin
                    done_next   = 1'b1;
                    sum_re_next = rd_data_reg.re;
                    sum_im_next = rd_data_reg.im;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_data.re = rd_data_reg.re + add_re;
                    wr_data.im = rd_data_reg.im + add_im;
                end
            end
            dmpt_pkg::ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_cnt_reg;
                wr_data = '0;
                if (clr_cnt_reg == '1)
                begin
                    init_next  = 1'b0;
                    state_next = dmpt_pkg::ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = dmpt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= dmpt_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            init_reg    <= 1'b1;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            init_reg    <= init_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        sum_re_reg <= sum_re_next;
        sum_im_reg <= sum_im_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign back_status.init_clear = init_reg;
    assign done                   = done_reg;
    assign sum_re                 = sum_re_reg;
    assign sum_im                 = sum_im_reg;

endmodule

### src/density_matrix_partial_trace.sv
// Partial trace over a configurable set of qubits. A transaction is taken on
// a clock edge where start is high and busy is low; opcode 0 adds an element
// into the reduced store, 1 reads one reduced element, 2 clears the store.
// Transactions pass through a four-entry queue to a read-modify-write engine
// on a 4096 x 76 bit store with one read and one write port: an accumulate
// passes the idle state (memory read) and the exec state (add and write back),
// a read the idle state and the exec state, which registers the result; the
// engine pops no new element until it is back in idle. A clear sweeps the
// store one entry per cycle. After reset the same sweep runs and busy stays
// high until it ends; configuration writes are taken meanwhile. A read passes
// the queue entry, the registered store read and the done and sum registers;
// done is then high for a single cycle with the result on sum_re and sum_im.
// The receiver cannot stall, so the result must be captured in that cycle.
// Busy also rises when the queue is full.
module density_matrix_partial_trace (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [1:0]                             opcode,
    input  logic [dmpt_pkg::MAX_QUBITS-1:0]        row_index,
    input  logic [dmpt_pkg::MAX_QUBITS-1:0]        col_index,
    input  logic signed [dmpt_pkg::VALUE_BITS-1:0] value_re,
    input  logic signed [dmpt_pkg::VALUE_BITS-1:0] value_im,
    output logic                                   done,
    output logic signed [dmpt_pkg::ACC_BITS-1:0]   sum_re,
    output logic signed [dmpt_pkg::ACC_BITS-1:0]   sum_im,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [dmpt_pkg::CFG_ADDR_BITS-1:0]     paddr,
    input  logic [dmpt_pkg::APB_DATA_BITS-1:0]     pwdata,
    output logic [dmpt_pkg::APB_DATA_BITS-1:0]     prdata,
    output logic                                   pready
);

    logic                   push;
    dmpt_pkg::cmd_t         push_cmd;
    logic                   pop;
    dmpt_pkg::cmd_t         head_cmd;
    logic                   queue_empty;
    logic                   queue_full;
    dmpt_pkg::back_status_t back_status;

    dmpt_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .opcode      (opcode),
        .row_index   (row_index),
        .col_index   (col_index),
        .value_re    (value_re),
        .value_im    (value_im),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .queue_full  (queue_full),
        .back_status (back_status),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    dmpt_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .empty    (queue_empty),
        .full     (queue_full)
    );

    dmpt_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_cmd    (head_cmd),
        .empty       (queue_empty),
        .pop         (pop),
        .back_status (back_status),
        .done        (done),
        .sum_re      (sum_re),
        .sum_im      (sum_im)
    );

endmodule

### src/dmpt_checker.sv
`include "density_matrix_partial_trace_assert.svh"

module dmpt_props (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   start,
    input logic                                   busy,
    input logic [1:0]                             opcode,
    input logic [dmpt_pkg::MAX_QUBITS-1:0]        row_index,
    input logic [dmpt_pkg::MAX_QUBITS-1:0]        col_index,
    input logic signed [dmpt_pkg::VALUE_BITS-1:0] value_re,
    input logic signed [dmpt_pkg::VALUE_BITS-1:0] value_im,
    input logic                                   done,
    input logic signed [dmpt_pkg::ACC_BITS-1:0]   sum_re,
    input logic signed [dmpt_pkg::ACC_BITS-1:0]   sum_im,
    input logic                                   psel,
    input logic                                   penable,
    input logic                                   pwrite,
    input logic [dmpt_pkg::CFG_ADDR_BITS-1:0]     paddr,
    input logic [dmpt_pkg::APB_DATA_BITS-1:0]     pwdata,
    input logic [dmpt_pkg::APB_DATA_BITS-1:0]     prdata,
    input logic                                   pready
);

    logic unused_inputs;

    assign unused_inputs = ^{start, busy, opcode, row_index, col_index, value_re,
                             value_im, sum_re, sum_im, penable, paddr, pwdata};

    // the configuration port never inserts wait states
    `DMPT_ASSERT_NOW(a_pready_high, clk, rst_n, 1'b1, pready)

    // the engine returns to idle after each read, so results never come back to back
    `DMPT_ASSERT_NEXT(a_done_spaced, clk, rst_n, done, !done)

    // register reads carry no bits beyond the widest register
    `DMPT_ASSERT_NOW(a_prdata_upper_zero, clk, rst_n, psel && !pwrite,
        prdata[dmpt_pkg::APB_DATA_BITS-1:dmpt_pkg::MAX_QUBITS] == '0)

endmodule

bind density_matrix_partial_trace dmpt_props u_checker (.*);
